// ===== hdl/array_list_store_unit_macros.svh =====
// assertion macros for the list store unit
`ifndef ARRAY_LIST_STORE_UNIT_MACROS_SVH
`define ARRAY_LIST_STORE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define ALS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("list store assertion failed");
// property checked at every edge, reset included
`define ALS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("list store assertion failed");
`else
`define ALS_ASSERT(lbl, clk, rst_n, prop)
`define ALS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== hdl/als_pkg.sv =====
package als_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 8;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DISPLAY = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_UPDATE  = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_in;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] element_value;
        logic [CNT_W-1:0]         element_position;
        logic [CNT_W-1:0]         fill_count;
        logic                     last_of_run;
    } t_out;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== hdl/als_cell.sv =====
module als_cell (
    input  logic                        i_clk,
    input  als_pkg::t_cell_ctl          i_ctl,
    input  logic [als_pkg::DATA_W-1:0]  i_next,
    input  logic [als_pkg::DATA_W-1:0]  i_wr_data,
    output logic [als_pkg::DATA_W-1:0]  o_data
);
    import als_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // direct write wins over taking the neighbor's word
    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_wr_data;
        end else if (i_ctl.shift) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hdl/array_list_store_unit.sv =====
// List store of up to CAPACITY signed 32-bit words held in a ring of cells, cell 0 at the
// head. Insert, delete and update finish in the cycle the item is accepted and give their
// result in the next cycle, so such items can follow every cycle while results are taken.
// Display and search walk the ring: every cell hands its word to the cell below once a cycle
// while no walk result waits on a stalled output, and the head word wraps to the tail, so after
// CAPACITY steps the list is back in order. A display or search item keeps the block busy
// until its walk ends, and the next item can be taken once it has ended. A display of n > 0
// elements gives n results, the last one marked; an empty display and every other action give
// one result. Action codes 5 to 7 are dropped silently.
`include "array_list_store_unit_macros.svh"

module array_list_store_unit #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  als_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output als_pkg::t_out o_out
);
    import als_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_step, n_step;
    logic              r_is_search, n_is_search;
    logic [DATA_W-1:0] r_key, n_key;
    logic              r_found, n_found;
    logic [CNT_W-1:0]  r_found_pos, n_found_pos;
    logic [CNT_W-1:0]  r_count, n_count;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    t_cell_ctl         cell_ctl  [CAPACITY];

    logic              in_acc;
    logic              out_free;
    logic [DATA_W-1:0] head;
    logic [POS_W-1:0]  pos_m1;
    logic              pos_ok;
    logic              ld_en;
    logic [IDX_W-1:0]  ld_idx;
    logic              del_en;
    logic              rot;
    logic [CNT_W-1:0]  step_pos;
    logic              in_range;
    logic              match;
    logic              emit_now;
    t_out              walk_item;

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign head     = cell_data[0];
    assign pos_m1   = i_in.position - 8'd1;
    assign pos_ok   = (i_in.position != 8'd0) && (i_in.position <= {1'b0, r_count});
    assign step_pos = CNT_W'(r_step) + 7'd1;
    assign in_range = CNT_W'(r_step) < r_count;
    assign match    = in_range && (head == r_key);

    // result of the current walk step
    always_comb begin
        walk_item = '0;
        walk_item.fill_count  = r_count;
        walk_item.last_of_run = 1'b1;
        if (r_is_search) begin
            emit_now = (r_step == LAST_STEP);
            if (r_found) begin
                walk_item.status           = ST_OK;
                walk_item.element_value    = r_key;
                walk_item.element_position = r_found_pos;
            end else if (match) begin
                walk_item.status           = ST_OK;
                walk_item.element_value    = r_key;
                walk_item.element_position = step_pos;
            end else begin
                walk_item.status = ST_NOT_FOUND;
            end
        end else begin
            emit_now = in_range;
            walk_item.status           = ST_OK;
            walk_item.element_value    = head;
            walk_item.element_position = step_pos;
            walk_item.last_of_run      = (step_pos == r_count);
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_is_search = r_is_search;
        n_key       = r_key;
        n_found     = r_found;
        n_found_pos = r_found_pos;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ld_en       = 1'b0;
        ld_idx      = r_count[IDX_W-1:0];
        del_en      = 1'b0;
        rot         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out = '0;
                    n_out.last_of_run = 1'b1;
                    n_out.fill_count  = r_count;
                    unique case (i_in.action)
                        ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            if (r_count >= CAP_CNT) begin
                                n_out.status = ST_FULL;
                            end else begin
                                ld_en   = 1'b1;
                                n_count = r_count + 7'd1;
                                n_out.status     = ST_OK;
                                n_out.fill_count = r_count + 7'd1;
                            end
                        end
                        ACT_DISPLAY: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = ST_EMPTY;
                            end else begin
                                n_state     = S_WALK;
                                n_step      = '0;
                                n_is_search = 1'b0;
                            end
                        end
                        ACT_SEARCH: begin
                            n_state     = S_WALK;
                            n_step      = '0;
                            n_is_search = 1'b1;
                            n_key       = i_in.value;
                            n_found     = 1'b0;
                        end
                        ACT_DELETE: begin
                            n_out_valid = 1'b1;
                            if (pos_ok) begin
                                del_en  = 1'b1;
                                n_count = r_count - 7'd1;
                                n_out.status     = ST_OK;
                                n_out.fill_count = r_count - 7'd1;
                            end else begin
                                n_out.status = ST_BAD_POS;
                            end
                        end
                        ACT_UPDATE: begin
                            n_out_valid = 1'b1;
                            if (pos_ok) begin
                                ld_en  = 1'b1;
                                ld_idx = pos_m1[IDX_W-1:0];
                                n_out.status = ST_OK;
                            end else begin
                                n_out.status = ST_BAD_POS;
                            end
                        end
                        default: begin
                            n_out_valid = r_out_valid && i_out_stall;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // hold the ring while a result is waiting on a stalled output
                if (!emit_now || out_free) begin
                    rot = 1'b1;
                    if (match && !r_found) begin
                        n_found     = 1'b1;
                        n_found_pos = step_pos;
                    end
                    if (emit_now) begin
                        n_out       = walk_item;
                        n_out_valid = 1'b1;
                    end
                    if (r_step == LAST_STEP) begin
                        n_step  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // per-cell controls: direct write, delete shift above the hole, or full rotation
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            cell_ctl[k].load  = ld_en && (ld_idx == IDX_W'(k));
            cell_ctl[k].shift = rot || (del_en && (IDX_W'(k) >= pos_m1[IDX_W-1:0]));
        end
    end

    // ring of cells, the tail takes the head word
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == CAPACITY - 1) begin : g_tail
            als_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl[g]),
                .i_next    (cell_data[0]),
                .i_wr_data (i_in.value),
                .o_data    (cell_data[g])
            );
        end else begin : g_body
            als_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (cell_ctl[g]),
                .i_next    (cell_data[g+1]),
                .i_wr_data (i_in.value),
                .o_data    (cell_data[g])
            );
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_found     <= n_found;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_is_search <= n_is_search;
        r_key       <= n_key;
        r_found_pos <= n_found_pos;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ALS_ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (r_state == S_IDLE && r_count == '0 && !r_out_valid))
    `ALS_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CAP_CNT)
    `ALS_ASSERT(a_count_hold, i_clk, i_rst_n, !in_acc |=> $stable(r_count))
    `ALS_ASSERT(a_partial_in_walk, i_clk, i_rst_n,
        (r_out_valid && !r_out.last_of_run) |-> (r_state == S_WALK))
    `ALS_ASSERT(a_display_walks, i_clk, i_rst_n,
        (in_acc && i_in.action == ACT_DISPLAY && r_count != '0) |=> (r_state == S_WALK))

endmodule
